/* src/kmst_pkg.sv */
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the minimum spanning tree unit.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int NODE_BITS     = 7;
    localparam int TOTAL_BITS    = 22;
    localparam int KIND_BITS     = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [NODE_BITS-1:0]            NODE_COUNT_RESET = 7'd64;
    localparam logic signed [CFG_DATA_BITS-1:0] NO_EDGE_RESET    = 16'sd9999;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_NO_EDGE    = 1'b1
    } cfg_index_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_EDGE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PASS,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_RDA,
        ST_RDB,
        ST_CHK,
        ST_RELAB,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_CLOSE
    } state_t;

endpackage

/* src/kmst_ram.sv */
// ----------------------------------------------------------------------------
// kmst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kmst_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/minimum_spanning_tree_kruskal_unit.sv */
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_unit
// Matrix entries load one per cycle while busy is low. A last entry raises
// busy for a run in which edges are examined in weight order; each
// examination rescans the weight RAM. Edge words each take a read state and
// an output state and cannot be stalled; the closing word comes in the same
// cycle that busy falls.
// Reset (async, low) resets the state, the valid flags and the configuration; the weight RAM is kept.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal_unit
    import kmst_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [NODE_BITS-1:0]          row_node,
    input  logic [NODE_BITS-1:0]          col_node,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    input  logic                          last_entry,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output logic                          result_valid,
    output logic [KIND_BITS-1:0]          kind,
    output logic [NODE_BITS-1:0]          edge_from,
    output logic [NODE_BITS-1:0]          edge_to,
    output logic signed [WEIGHT_BITS-1:0] edge_weight,
    output logic signed [TOTAL_BITS-1:0]  total_weight,
    output logic                          last_result
);

    localparam int IDX  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW   = ((WEIGHT_BITS > CFG_DATA_BITS) ? WEIGHT_BITS : CFG_DATA_BITS) + 1;
    localparam int SW   = 2 * IDX + WEIGHT_BITS;
    localparam logic [IDX-1:0]       K_LAST = IDX'(MAX_NODES - 1);
    localparam logic [NODE_BITS-1:0] N_MAX  = NODE_BITS'(MAX_NODES);

    // configuration
    logic [NODE_BITS-1:0]            nc_reg;
    logic signed [CFG_DATA_BITS-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg  <= NODE_COUNT_RESET;
            thr_reg <= NO_EDGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NODE_COUNT: nc_reg  <= cfg_data[NODE_BITS-1:0];
                CFG_NO_EDGE:    thr_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // weight RAM
    logic                   accept;
    logic                   w_we;
    logic [2*IDX-1:0]       w_waddr, w_raddr;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [NODE_BITS-1:0]   row_m1, col_m1;

    assign accept = start && !busy;
    assign row_m1 = row_node - NODE_BITS'(1);
    assign col_m1 = col_node - NODE_BITS'(1);
    assign w_we   = accept && (row_node != '0) && (col_node != '0)
                    && (row_node <= N_MAX) && (col_node <= N_MAX)
                    && (row_node < col_node);
    assign w_waddr = {row_m1[IDX-1:0], col_m1[IDX-1:0]};

    kmst_ram #(
        .ADDR_BITS (2 * IDX),
        .DATA_BITS (WEIGHT_BITS)
    ) u_wstore (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (weight),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // set RAM: labels in the lower half, picked edges in the upper half
    logic           s_we;
    logic [IDX:0]   s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;

    kmst_ram #(
        .ADDR_BITS (IDX + 1),
        .DATA_BITS (SW)
    ) u_setmem (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // control registers
    state_t                         state_reg, state_next;
    logic [NODE_BITS-1:0]           n_reg, n_next;
    logic [IDX-1:0]                 acc_reg, acc_next;
    logic [IDX-1:0]                 e_reg, e_next;
    logic [IDX-1:0]                 k_reg, k_next;
    logic [IDX-1:0]                 i_reg, i_next, j_reg, j_next;
    logic                           sv_reg, sv_next;
    logic [2*IDX-1:0]               sidx_reg, sidx_next;
    logic                           found_reg, found_next;
    logic [2*IDX-1:0]               bidx_reg, bidx_next;
    logic signed [WEIGHT_BITS-1:0]  bw_reg, bw_next;
    logic                           hl_reg, hl_next;
    logic [2*IDX-1:0]               lidx_reg, lidx_next;
    logic signed [WEIGHT_BITS-1:0]  lw_reg, lw_next;
    logic [IDX-1:0]                 la_reg, la_next, lb_reg, lb_next;
    logic                           rv_reg, rv_next;
    logic [IDX-1:0]                 rk_reg, rk_next;
    logic signed [TOTAL_BITS-1:0]   tot_reg, tot_next;
    logic signed [TOTAL_BITS-1:0]   etot_reg, etot_next;
    logic                           ov_reg, ov_next;
    kind_t                          kind_reg, kind_next;
    logic [NODE_BITS-1:0]           from_reg, from_next, to_reg, to_next;
    logic signed [WEIGHT_BITS-1:0]  ew_reg, ew_next;
    logic signed [TOTAL_BITS-1:0]   otot_reg, otot_next;
    logic                           olast_reg, olast_next;

    // helpers
    logic signed [WEIGHT_BITS-1:0] sw;
    logic signed [CW-1:0]          sw_x, thr_x;
    logic                          cand;
    logic [IDX-1:0]                n_m1, n_m2;
    logic                          more;
    logic signed [WEIGHT_BITS-1:0] pw;
    logic [IDX-1:0]                plo, phi;
    logic signed [63:0]            bw_64, pw_64;
    logic [NODE_BITS-1:0]          n_eff;

    assign sw    = w_rdata;
    assign sw_x  = {{(CW-WEIGHT_BITS){sw[WEIGHT_BITS-1]}}, sw};
    assign thr_x = {{(CW-CFG_DATA_BITS){thr_reg[CFG_DATA_BITS-1]}}, thr_reg};
    assign cand  = sv_reg && (sw_x < thr_x)
                   && (!hl_reg || (sw > lw_reg) || ((sw == lw_reg) && (sidx_reg > lidx_reg)))
                   && (!found_reg || (sw < bw_reg));
    assign n_m1  = IDX'(n_reg - NODE_BITS'(1));
    assign n_m2  = IDX'(n_reg - NODE_BITS'(2));
    assign more  = ({1'b0, acc_reg} + (IDX+1)'(1)) < (IDX+1)'(n_reg);
    assign pw    = s_rdata[WEIGHT_BITS-1:0];
    assign phi   = s_rdata[WEIGHT_BITS+IDX-1:WEIGHT_BITS];
    assign plo   = s_rdata[WEIGHT_BITS+2*IDX-1:WEIGHT_BITS+IDX];
    assign bw_64 = {{(64-WEIGHT_BITS){bw_reg[WEIGHT_BITS-1]}}, bw_reg};
    assign pw_64 = {{(64-WEIGHT_BITS){pw[WEIGHT_BITS-1]}}, pw};
    assign n_eff = (nc_reg == '0) ? NODE_BITS'(1) : ((nc_reg > N_MAX) ? N_MAX : nc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sv_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sv_reg    <= sv_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        acc_reg   <= acc_next;
        e_reg     <= e_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        sidx_reg  <= sidx_next;
        found_reg <= found_next;
        bidx_reg  <= bidx_next;
        bw_reg    <= bw_next;
        hl_reg    <= hl_next;
        lidx_reg  <= lidx_next;
        lw_reg    <= lw_next;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        rk_reg    <= rk_next;
        tot_reg   <= tot_next;
        etot_reg  <= etot_next;
        kind_reg  <= kind_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        ew_reg    <= ew_next;
        otot_reg  <= otot_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        acc_next   = acc_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        sv_next    = 1'b0;
        sidx_next  = {i_reg, j_reg};
        found_next = found_reg;
        bidx_next  = bidx_reg;
        bw_next    = bw_reg;
        hl_next    = hl_reg;
        lidx_next  = lidx_reg;
        lw_next    = lw_reg;
        la_next    = la_reg;
        lb_next    = lb_reg;
        rv_next    = 1'b0;
        rk_next    = k_reg;
        tot_next   = tot_reg;
        etot_next  = etot_reg;
        ov_next    = 1'b0;
        kind_next  = kind_reg;
        from_next  = from_reg;
        to_next    = to_reg;
        ew_next    = ew_reg;
        otot_next  = otot_reg;
        olast_next = olast_reg;
        w_raddr    = {i_reg, j_reg};
        s_raddr    = {1'b0, k_reg};
        s_we       = 1'b0;
        s_waddr    = {1'b0, k_reg};
        s_wdata    = SW'(k_reg);

        if (cand)
        begin
            found_next = 1'b1;
            bw_next    = sw;
            bidx_next  = sidx_reg;
        end

        // trailing relabel write
        if (rv_reg && (s_rdata[IDX-1:0] == lb_reg))
        begin
            s_we    = 1'b1;
            s_waddr = {1'b0, rk_reg};
            s_wdata = SW'(la_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_entry)
                begin
                    n_next     = n_eff;
                    acc_next   = '0;
                    tot_next   = '0;
                    hl_next    = 1'b0;
                    k_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = {1'b0, k_reg};
                s_wdata = SW'(k_reg);
                k_next  = k_reg + IDX'(1);
                if (k_reg == K_LAST)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (more)
                begin
                    i_next     = '0;
                    j_next     = IDX'(1);
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    e_next     = '0;
                    etot_next  = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SCAN:
            begin
                sv_next = 1'b1;
                if (j_reg == n_m1)
                begin
                    if (i_reg == n_m2)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + IDX'(1);
                        j_next = i_reg + IDX'(2);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (found_reg)
                begin
                    hl_next    = 1'b1;
                    lidx_next  = bidx_reg;
                    lw_next    = bw_reg;
                    state_next = ST_RDA;
                end
                else
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_RDA:
            begin
                s_raddr    = {1'b0, lidx_reg[2*IDX-1:IDX]};
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                s_raddr    = {1'b0, lidx_reg[IDX-1:0]};
                la_next    = s_rdata[IDX-1:0];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                lb_next = s_rdata[IDX-1:0];
                if (s_rdata[IDX-1:0] == la_reg)
                begin
                    state_next = ST_PASS;
                end
                else
                begin
                    s_we       = 1'b1;
                    s_waddr    = {1'b1, acc_reg};
                    s_wdata    = {lidx_reg, lw_reg};
                    acc_next   = acc_reg + IDX'(1);
                    tot_next   = tot_reg + bw_64[TOTAL_BITS-1:0];
                    k_next     = '0;
                    state_next = ST_RELAB;
                end
            end
            ST_RELAB:
            begin
                s_raddr = {1'b0, k_reg};
                rv_next = 1'b1;
                rk_next = k_reg;
                k_next  = k_reg + IDX'(1);
                if (k_reg == K_LAST)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_EMIT_RD:
            begin
                s_raddr = {1'b1, e_reg};
                if (e_reg == acc_reg)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT:
            begin
                ov_next    = 1'b1;
                kind_next  = KIND_EDGE;
                from_next  = NODE_BITS'(plo) + NODE_BITS'(1);
                to_next    = NODE_BITS'(phi) + NODE_BITS'(1);
                ew_next    = pw;
                otot_next  = etot_reg + pw_64[TOTAL_BITS-1:0];
                etot_next  = etot_reg + pw_64[TOTAL_BITS-1:0];
                olast_next = 1'b0;
                e_next     = e_reg + IDX'(1);
                state_next = ST_EMIT_RD;
            end
            ST_CLOSE:
            begin
                ov_next    = 1'b1;
                kind_next  = more ? KIND_NONE : KIND_DONE;
                from_next  = '0;
                to_next    = '0;
                ew_next    = '0;
                otot_next  = tot_reg;
                olast_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = ov_reg;
    assign kind         = kind_reg;
    assign edge_from    = from_reg;
    assign edge_to      = to_reg;
    assign edge_weight  = ew_reg;
    assign total_weight = otot_reg;
    assign last_result  = olast_reg;

endmodule

/* src/kmst_checker.sv */
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks of the spanning tree unit's run start and result sequence.
// ----------------------------------------------------------------------------
module kmst_checker
    import kmst_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          last_entry,
    input logic                          result_valid,
    input logic [KIND_BITS-1:0]          kind,
    input logic [NODE_BITS-1:0]          edge_from,
    input logic [NODE_BITS-1:0]          edge_to,
    input logic signed [WEIGHT_BITS-1:0] edge_weight,
    input logic                          last_result
);

    localparam logic [NODE_BITS-1:0] N_MAX = NODE_BITS'(MAX_NODES);

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_entry |=> busy)
        else $error("run did not start");

    a_close_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("word after closing word");

    a_edge_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_EDGE) |-> !last_result)
        else $error("edge word marked last");

    a_close_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |-> (kind == KIND_DONE || kind == KIND_NONE)
            && edge_from == '0 && edge_to == '0 && edge_weight == '0)
        else $error("bad closing word");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |-> edge_from != '0 && edge_from < edge_to
            && edge_to <= N_MAX)
        else $error("bad edge vertices");

endmodule

bind minimum_spanning_tree_kruskal_unit kmst_checker #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
) u_kmst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_entry   (last_entry),
    .result_valid (result_valid),
    .kind         (kind),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .edge_weight  (edge_weight),
    .last_result  (last_result)
);

/* verif/tb_minimum_spanning_tree_kruskal_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minimum_spanning_tree_kruskal_unit
// Loads matrix entries into the spanning tree unit under several vertex counts
// and no-edge thresholds. Every run is predicted in the bench and the result
// words are checked field by field as they come out.
// ----------------------------------------------------------------------------
module tb_minimum_spanning_tree_kruskal_unit;
    import kmst_pkg::*;

    localparam int NODES = 64;
    localparam int WBITS = 16;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [NODE_BITS-1:0]     row;
        logic [NODE_BITS-1:0]     col;
        logic signed [WBITS-1:0]  w;
        logic                     last;
    } entry_word_t;

    typedef struct {
        kind_t                        kind;
        logic [NODE_BITS-1:0]         from;
        logic [NODE_BITS-1:0]         to;
        logic signed [WBITS-1:0]      w;
        logic signed [TOTAL_BITS-1:0] tot;
        logic                         last;
    } tree_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [NODE_BITS-1:0] row_node;
    logic [NODE_BITS-1:0] col_node;
    logic signed [WBITS-1:0] weight;
    logic last_entry;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic result_valid;
    logic [KIND_BITS-1:0] kind;
    logic [NODE_BITS-1:0] edge_from;
    logic [NODE_BITS-1:0] edge_to;
    logic signed [WBITS-1:0] edge_weight;
    logic signed [TOTAL_BITS-1:0] total_weight;
    logic last_result;

    entry_word_t pending_entries[$];
    tree_word_t  expected_words[$];

    logic signed [WBITS-1:0] shadow_store[NODES][NODES];
    logic [NODE_BITS-1:0]    shadow_nodes;
    logic signed [WBITS-1:0] shadow_no_edge;
    int uf_parent[NODES];
    int uf_size[NODES];

    int  errors;
    int  gap;
    int  idle_cycles;
    bit  quiet;

    minimum_spanning_tree_kruskal_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .row_node(row_node), .col_node(col_node), .weight(weight),
        .last_entry(last_entry), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .kind(kind),
        .edge_from(edge_from), .edge_to(edge_to), .edge_weight(edge_weight),
        .total_weight(total_weight), .last_result(last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int find_root(int x);
        int r;
        int nx;
        r = x;
        while (uf_parent[r] != r)
            r = uf_parent[r];
        while (x != r)
        begin
            nx = uf_parent[x];
            uf_parent[x] = r;
            x = nx;
        end
        return r;
    endfunction

    // Kruskal over the shadow store; ties stay in row-major order
    function automatic void predict_tree();
        int elo[2016];
        int ehi[2016];
        int ew[2016];
        int plo[NODES];
        int phi[NODES];
        int pw[NODES];
        int n;
        int cnt;
        int p;
        int acc;
        int a;
        int b;
        int t;
        longint tot;
        tree_word_t wd;
        n = shadow_nodes;
        if (n < 1) n = 1;
        if (n > NODES) n = NODES;
        for (int i = 0; i < NODES; i++)
        begin
            uf_parent[i] = i;
            uf_size[i] = 1;
        end
        cnt = 0;
        for (int i = 0; i + 1 < n; i++)
            for (int j = i + 1; j < n; j++)
                if (shadow_store[i][j] < shadow_no_edge)
                begin
                    p = cnt;
                    while (p > 0 && ew[p-1] > shadow_store[i][j])
                    begin
                        elo[p] = elo[p-1];
                        ehi[p] = ehi[p-1];
                        ew[p] = ew[p-1];
                        p--;
                    end
                    elo[p] = i + 1;
                    ehi[p] = j + 1;
                    ew[p] = shadow_store[i][j];
                    cnt++;
                end
        acc = 0;
        tot = 0;
        for (int i = 0; i < cnt && acc + 1 < n; i++)
        begin
            a = find_root(elo[i] - 1);
            b = find_root(ehi[i] - 1);
            if (a != b)
            begin
                if (uf_size[a] < uf_size[b])
                begin
                    t = a; a = b; b = t;
                end
                uf_parent[b] = a;
                uf_size[a] = uf_size[a] + uf_size[b];
                plo[acc] = elo[i];
                phi[acc] = ehi[i];
                pw[acc] = ew[i];
                acc++;
                tot += ew[i];
            end
        end
        wd.from = '0;
        wd.to = '0;
        wd.w = '0;
        wd.last = 1'b1;
        if (acc + 1 < n)
        begin
            wd.kind = KIND_NONE;
            wd.tot = tot[TOTAL_BITS-1:0];
            expected_words = {expected_words, wd};
            return;
        end
        tot = 0;
        for (int i = 0; i < acc; i++)
        begin
            tot += pw[i];
            wd.kind = KIND_EDGE;
            wd.from = NODE_BITS'(plo[i]);
            wd.to = NODE_BITS'(phi[i]);
            wd.w = WBITS'(pw[i]);
            wd.tot = tot[TOTAL_BITS-1:0];
            wd.last = 1'b0;
            expected_words = {expected_words, wd};
        end
        wd.kind = KIND_DONE;
        wd.from = '0;
        wd.to = '0;
        wd.w = '0;
        wd.tot = tot[TOTAL_BITS-1:0];
        wd.last = 1'b1;
        expected_words = {expected_words, wd};
    endfunction

    function automatic void absorb_entry(entry_word_t e);
        if (e.row >= 1 && e.col >= 1 && e.row <= NODES && e.col <= NODES && e.row < e.col)
            shadow_store[e.row-1][e.col-1] = e.w;
        if (e.last)
            predict_tree();
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            row_node <= '0;
            col_node <= '0;
            weight <= '0;
            last_entry <= 1'b0;
            gap <= 0;
        end
        else
        begin
            if (start && !busy)
                absorb_entry('{row_node, col_node, weight, last_entry});
            if (!start || !busy)
            begin
                if (gap > 0)
                begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end
                else if (pending_entries.size() > 0)
                begin
                    entry_word_t e;
                    e = pending_entries.pop_front();
                    row_node <= e.row;
                    col_node <= e.col;
                    weight <= e.w;
                    last_entry <= e.last;
                    start <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0)
                        gap <= $urandom_range(1, 11);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word kind %0d", kind);
                    errors++;
                end
                else
                begin
                    tree_word_t x;
                    x = expected_words.pop_front();
                    if (kind !== x.kind)
                    begin
                        $error("kind: expected %0d, got %0d", x.kind, kind);
                        errors++;
                    end
                    if (edge_from !== x.from)
                    begin
                        $error("edge_from: expected %0d, got %0d", x.from, edge_from);
                        errors++;
                    end
                    if (edge_to !== x.to)
                    begin
                        $error("edge_to: expected %0d, got %0d", x.to, edge_to);
                        errors++;
                    end
                    if (edge_weight !== x.w)
                    begin
                        $error("edge_weight: expected %0d, got %0d", x.w, edge_weight);
                        errors++;
                    end
                    if (total_weight !== x.tot)
                    begin
                        $error("total_weight: expected %0d, got %0d", x.tot, total_weight);
                        errors++;
                    end
                    if (last_result !== x.last)
                    begin
                        $error("last_result: expected %0d, got %0d", x.last, last_result);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_entry(int r, int c, int w, bit last);
        entry_word_t e;
        e.row = NODE_BITS'(r);
        e.col = NODE_BITS'(c);
        e.w = WBITS'(w);
        e.last = last;
        pending_entries = {pending_entries, e};
    endtask

    task automatic settle();
        while (pending_entries.size() > 0 || start || busy || expected_words.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_NODE_COUNT)
            shadow_nodes = val[NODE_BITS-1:0];
        else
            shadow_no_edge = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_weight();
        if ($urandom_range(0, 7) == 0)
            return $signed(16'($urandom()));
        return $urandom_range(0, 20) - 8;
    endfunction

    task automatic random_phase(int n, int thr, int extra);
        int r;
        int c;
        write_reg(CFG_NODE_COUNT, CFG_DATA_BITS'(n));
        write_reg(CFG_NO_EDGE, CFG_DATA_BITS'(thr));
        for (int i = 1; i < n; i++)
            for (int j = i + 1; j <= n; j++)
                push_entry(i, j, rand_weight(), 1'b0);
        for (int k = 0; k < extra; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r = $urandom_range(0, 127);
                c = $urandom_range(0, 127);
            end
            else
            begin
                r = $urandom_range(1, n);
                c = $urandom_range(1, n);
                if ($urandom_range(0, 4) != 0 && r > c)
                begin
                    int t;
                    t = r; r = c; c = t;
                end
            end
            push_entry(r, c, rand_weight(), k == extra - 1 || $urandom_range(0, 4) == 0);
        end
        settle();
    endtask

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        shadow_nodes = NODE_COUNT_RESET;
        shadow_no_edge = NO_EDGE_RESET;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // node count zero acts as one; lower triangle, diagonal, bad vertices
        write_reg(CFG_NODE_COUNT, CFG_DATA_BITS'(0));
        push_entry(3, 2, 5, 1'b0);
        push_entry(4, 4, 5, 1'b0);
        push_entry(0, 127, -1, 1'b0);
        push_entry(65, 66, 7, 1'b1);
        settle();

        // four vertices: extremes and ties under the reset threshold
        write_reg(CFG_NODE_COUNT, CFG_DATA_BITS'(4));
        push_entry(1, 2, -32768, 1'b0);
        push_entry(1, 3, 3, 1'b0);
        push_entry(1, 4, 3, 1'b0);
        push_entry(2, 3, 3, 1'b0);
        push_entry(2, 4, 9999, 1'b0);
        push_entry(3, 4, 32767, 1'b1);
        push_entry(1, 4, 10000, 1'b1);
        push_entry(1, 3, 9999, 1'b0);
        push_entry(2, 3, 9998, 1'b1);
        settle();

        // threshold extremes
        write_reg(CFG_NO_EDGE, 16'h7fff);
        push_entry(3, 4, 32766, 1'b1);
        settle();
        write_reg(CFG_NO_EDGE, 16'h8000);
        push_entry(1, 2, -32768, 1'b1);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph >= 4)
                quiet = 1'b1;
            random_phase($urandom_range(2, 8),
                         ($urandom_range(0, 3) == 0) ? $signed(16'($urandom()))
                                                     : $urandom_range(0, 12),
                         $urandom_range(4, 10));
        end

        settle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
